// ===== rtl/atp_pkg.sv =====
package atp_pkg;

  localparam int unsigned GUARD      = 12;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned ANGLE_FRAC = 16;
  localparam int unsigned OUT_W      = 15;
  localparam int unsigned IN_W       = 16;
  localparam int unsigned OFFSET_CD  = 9000;
  localparam int unsigned FULL_CD    = 18000;

  localparam longint ATAN_TAB [TABLE_LEN] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  // per-angle override for degenerate inputs
  typedef struct packed {
    logic               pitch_en;
    logic [OUT_W-1:0]   pitch_val;
    logic               roll_en;
    logic [OUT_W-1:0]   roll_val;
  } sp_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    rem  = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // ceil(a / b) by shift and subtract, elaboration only
  function automatic longint unsigned ceil_div64(input longint unsigned a,
                                                 input longint unsigned b);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((a >> i) & 64'd1);
      if (rem >= b) begin
        rem = rem - b;
        quo = quo | (64'd1 << i);
      end
    end
    if (rem != 0) quo = quo + 64'd1;
    return quo;
  endfunction

  // 1/K in Q24 for n iterations
  function automatic longint unsigned inv_gain(input int unsigned n);
    longint unsigned k;
    longint unsigned one60;
    longint unsigned d;
    longint unsigned q;
    k     = 64'd1 << 30;
    one60 = 64'd1 << 60;
    for (int unsigned i = 0; i < n; i++) begin
      d = (64'd1 << (2 * i)) + 64'd1;
      q = one60 - ceil_div64(one60, d);
      k = (k * isqrt64(q)) >> 30;
    end
    return k >> 6;
  endfunction

endpackage

// ===== rtl/accel_tilt_pitch_roll_unit.sv =====
// Tilt unit: one accelerometer sample in, pitch and roll (+90 deg, centidegrees) out.
// Input stream s_axis: tdata = {z, y, x}, 16-bit two's complement each, x lowest.
// Output stream m_axis: tdata = {roll, pitch}, 15 bits each, pitch lowest, zero padded.
// Each output angle is in 0..18000; 9000 means level.
// Throughput: one request per cycle while m_axis_tready stays high.
// Pipeline from the input accept to output valid: input register, queue entry,
// lane input stage, two CORDIC chains (steps capped at 24), gain multiply in two
// stages, output register.
// The back end is a pipeline that halts as a whole while a result sits
// unaccepted in the output register; the front register and the queue keep
// taking up to three more requests, then s_axis_tready drops.
// Reset clears all valid flags; no requests are lost or invented after reset.
module accel_tilt_pitch_roll_unit #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [14:0] pitch_centideg, [29:15] roll_centideg
);
  import atp_pkg::*;

  localparam int unsigned N   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int unsigned LAT = 2 * N + 3;
  localparam int unsigned QW  = 3 * SAMPLE_BITS + $bits(sp_t);

  logic                          f_valid, q_ready, q_valid, adv;
  logic signed [SAMPLE_BITS-1:0] fx, fy, fz, qx, qy, qz;
  sp_t                           fsp, qsp;
  logic [QW-1:0]                 q_out;
  logic [LAT-1:0]                vp_q;
  logic                          ov_q;
  logic [OUT_W-1:0]              pitch_q, roll_q, pitch_w, roll_w;

  atp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .x_i          (s_axis_tdata[15:0]),
    .y_i          (s_axis_tdata[31:16]),
    .z_i          (s_axis_tdata[47:32]),
    .push_valid_o (f_valid),
    .push_ready_i (q_ready),
    .x_o (fx), .y_o (fy), .z_o (fz),
    .sp_o (fsp)
  );

  atp_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i       (f_valid),
    .push_ready_o (q_ready),
    .push_data_i  ({fx, fy, fz, fsp}),
    .pop_valid_o  (q_valid),
    .pop_i        (adv),
    .pop_data_o   (q_out)
  );

  assign {qx, qy, qz, qsp} = q_out;
  assign adv = !ov_q || m_axis_tready;

  atp_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i, .en_i (adv),
    .num_i (qx), .da_i (qy), .db_i (qz),
    .sp_en_i (qsp.pitch_en), .sp_val_i (qsp.pitch_val),
    .res_o (pitch_w)
  );

  atp_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i, .en_i (adv),
    .num_i (qy), .da_i (qx), .db_i (qz),
    .sp_en_i (qsp.roll_en), .sp_val_i (qsp.roll_val),
    .res_o (roll_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      vp_q <= {vp_q[LAT-2:0], q_valid};
      ov_q <= vp_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pitch_q <= pitch_w;
      roll_q  <= roll_w;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, roll_q, pitch_q};

  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> $stable(vp_q))
    else $error("pipeline moved while output stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (pitch_q <= OUT_W'(FULL_CD) && roll_q <= OUT_W'(FULL_CD)))
    else $error("angle out of range");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vp_q) <= LAT)
    else $error("pipeline occupancy corrupt");

endmodule

// ===== rtl/atp_front.sv =====
module atp_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [atp_pkg::IN_W-1:0]      x_i,
  input  logic [atp_pkg::IN_W-1:0]      y_i,
  input  logic [atp_pkg::IN_W-1:0]      z_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic signed [SAMPLE_BITS-1:0] x_o,
  output logic signed [SAMPLE_BITS-1:0] y_o,
  output logic signed [SAMPLE_BITS-1:0] z_o,
  output atp_pkg::sp_t                  sp_o
);
  import atp_pkg::*;

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, z_q;
  sp_t                           sp_q, sp_d;
  logic [23:0]                   xw, yw, zw;
  logic signed [SAMPLE_BITS-1:0] xs, ys, zs;

  assign xw = 24'(x_i);
  assign yw = 24'(y_i);
  assign zw = 24'(z_i);
  assign xs = xw[SAMPLE_BITS-1:0];
  assign ys = yw[SAMPLE_BITS-1:0];
  assign zs = zw[SAMPLE_BITS-1:0];

  function automatic logic [OUT_W-1:0] deg_val(input logic signed [SAMPLE_BITS-1:0] num);
    logic [OUT_W-1:0] r;
    r = OUT_W'(OFFSET_CD);
    if (num > 0) r = OUT_W'(FULL_CD);
    else if (num < 0) r = '0;
    return r;
  endfunction

  always_comb begin
    sp_d.pitch_en  = (ys == 0 && zs == 0) || xs == 0;
    sp_d.pitch_val = deg_val(xs);
    sp_d.roll_en   = (xs == 0 && zs == 0) || ys == 0;
    sp_d.roll_val  = deg_val(ys);
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign sp_o = sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q  <= xs;
      y_q  <= ys;
      z_q  <= zs;
      sp_q <= sp_d;
    end
  end

endmodule

// ===== rtl/atp_queue.sv =====
module atp_queue #(
  parameter int unsigned WIDTH = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/atp_lane.sv =====
module atp_lane #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] num_i,
  input  logic signed [SAMPLE_BITS-1:0] da_i,
  input  logic signed [SAMPLE_BITS-1:0] db_i,
  input  logic                          sp_en_i,
  input  logic [atp_pkg::OUT_W-1:0]     sp_val_i,
  output logic [atp_pkg::OUT_W-1:0]     res_o
);
  import atp_pkg::*;

  localparam int unsigned N   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int unsigned W   = SAMPLE_BITS + GUARD + 4;
  localparam int unsigned LAT = 2 * N + 3;
  localparam longint unsigned IG = inv_gain(N);
  localparam logic [11:0] IG_HI = 12'(IG >> 12);
  localparam logic [11:0] IG_LO = 12'(IG);
  localparam int unsigned ZW  = 33;

  logic signed [W-1:0]  mx_q [N+1];
  logic signed [W-1:0]  my_q [N+1];
  logic signed [W-1:0]  mn_q [N+1];
  logic [W+11:0]        ph_q, pl_q;
  logic signed [W-1:0]  pn_q;
  logic signed [W-1:0]  ax_q [N+1];
  logic signed [W-1:0]  ay_q [N+1];
  logic signed [ZW-1:0] az_q [N+1];
  logic [OUT_W:0]       sp_q [LAT];
  logic signed [W-1:0]  da_w, db_w;
  logic [W+23:0]        msum;
  logic signed [ZW:0]   t;
  logic [ZW:0]          tu;

  assign da_w = W'(da_i);
  assign db_w = W'(db_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q[0] <= (da_w < 0 ? -da_w : da_w) <<< GUARD;
      my_q[0] <= (db_w < 0 ? -db_w : db_w) <<< GUARD;
      mn_q[0] <= W'(num_i) <<< GUARD;
      sp_q[0] <= {sp_en_i, sp_val_i};
    end
  end

  for (genvar s = 1; s < LAT; s++) begin : g_sp
    always_ff @(posedge clk_i) begin
      if (en_i) sp_q[s] <= sp_q[s-1];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_mag
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mn_q[i+1] <= mn_q[i];
        if (my_q[i] >= 0) begin
          mx_q[i+1] <= mx_q[i] + (my_q[i] >>> i);
          my_q[i+1] <= my_q[i] - (mx_q[i] >>> i);
        end else begin
          mx_q[i+1] <= mx_q[i] - (my_q[i] >>> i);
          my_q[i+1] <= my_q[i] + (mx_q[i] >>> i);
        end
      end
    end
  end

  assign msum = ((W + 24)'(ph_q) << 12) + (W + 24)'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q    <= (W + 12)'(unsigned'(mx_q[N])) * (W + 12)'(IG_HI);
      pl_q    <= (W + 12)'(unsigned'(mx_q[N])) * (W + 12)'(IG_LO);
      pn_q    <= mn_q[N];
      ax_q[0] <= W'(msum >> 24);
      ay_q[0] <= pn_q;
      az_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_atan
    localparam logic signed [ZW-1:0] A = ZW'(ATAN_TAB[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ay_q[i] >= 0) begin
          ax_q[i+1] <= ax_q[i] + (ay_q[i] >>> i);
          ay_q[i+1] <= ay_q[i] - (ax_q[i] >>> i);
          az_q[i+1] <= az_q[i] + A;
        end else begin
          ax_q[i+1] <= ax_q[i] - (ay_q[i] >>> i);
          ay_q[i+1] <= ay_q[i] + (ax_q[i] >>> i);
          az_q[i+1] <= az_q[i] - A;
        end
      end
    end
  end

  always_comb begin
    t  = (ZW + 1)'(az_q[N]) + (ZW + 1)'(OFFSET_CD * (64'd1 << ANGLE_FRAC));
    tu = unsigned'(t) >> ANGLE_FRAC;
    if (sp_q[LAT-1][OUT_W]) res_o = sp_q[LAT-1][OUT_W-1:0];
    else if (t < 0) res_o = '0;
    else if (tu > (ZW + 1)'(FULL_CD)) res_o = OUT_W'(FULL_CD);
    else res_o = tu[OUT_W-1:0];
  end

endmodule

// ===== dv/tilt_checker.sv =====
module tilt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import atp_pkg::*;

  localparam int unsigned STEPS = 16;

  typedef struct packed {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] roll;
  } angles_t;

  angles_t angle_q[$];
  longint unsigned gain_q24;

  function automatic longint arsh(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic logic [OUT_W-1:0] tilt_angle(input longint num, input longint da,
                                                  input longint db);
    longint x, y, z, nx, t;
    longint unsigned mag;
    if (da == 0 && db == 0) begin
      if (num > 0) return OUT_W'(FULL_CD);
      if (num < 0) return '0;
      return OUT_W'(OFFSET_CD);
    end
    if (num == 0) return OUT_W'(OFFSET_CD);
    x = (da < 0 ? -da : da) <<< GUARD;
    y = (db < 0 ? -db : db) <<< GUARD;
    for (int unsigned i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + arsh(y, i);
        y  = y - arsh(x, i);
      end else begin
        nx = x - arsh(y, i);
        y  = y + arsh(x, i);
      end
      x = nx;
    end
    mag = (longint'(x) * gain_q24) >> 24;
    x = longint'(mag);
    y = num <<< GUARD;
    z = 0;
    for (int unsigned i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + arsh(y, i);
        y  = y - arsh(x, i);
        z += ATAN_TAB[i];
      end else begin
        nx = x - arsh(y, i);
        y  = y + arsh(x, i);
        z -= ATAN_TAB[i];
      end
      x = nx;
    end
    t = z + (longint'(OFFSET_CD) <<< ANGLE_FRAC);
    if (t < 0) return '0;
    mag = longint'(t) >> ANGLE_FRAC;
    return (mag > FULL_CD) ? OUT_W'(FULL_CD) : mag[OUT_W-1:0];
  endfunction

  // local 1/K in Q24, same truncation rules as the block
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  initial begin
    longint unsigned k, d, q, one60;
    k = 64'd1 << 30;
    one60 = 64'd1 << 60;
    for (int unsigned i = 0; i < STEPS; i++) begin
      d = (64'd1 << (2 * i)) + 1;
      q = one60 - (one60 + d - 1) / d;
      k = (k * root64(q)) >> 30;
    end
    gain_q24 = k >> 6;
  end

  initial fail_count_o = 0;
  assign pending_o = angle_q.size();

  always @(posedge clk_i) begin
    longint ax, ay, az;
    angles_t exp_a;
    int errs;
    errs = 0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      ax = longint'($signed(s_axis_tdata[15:0]));
      ay = longint'($signed(s_axis_tdata[31:16]));
      az = longint'($signed(s_axis_tdata[47:32]));
      angle_q.push_back('{pitch: tilt_angle(ax, ay, az), roll: tilt_angle(ay, ax, az)});
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errs++;
      end else begin
        exp_a = angle_q.pop_front();
        if (m_axis_tdata[14:0] !== exp_a.pitch) begin
          $error("pitch_centideg exp %0d got %0d", exp_a.pitch, m_axis_tdata[14:0]);
          errs++;
        end
        if (m_axis_tdata[29:15] !== exp_a.roll) begin
          $error("roll_centideg exp %0d got %0d", exp_a.roll, m_axis_tdata[29:15]);
          errs++;
        end
      end
    end
    if (errs != 0) fail_count_o <= fail_count_o + errs;
  end
endmodule

// ===== dv/tb.sv =====
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count, pending;
  int          send_idle_pct = 31, recv_idle_pct = 88;
  longint      cycle_count = 0;

  always #5 clk_i = ~clk_i;

  accel_tilt_pitch_roll_unit dut (.*);

  tilt_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'($urandom_range(32767));
      1: return 16'($signed(-$urandom_range(32768)));
      2: return 16'($signed($urandom_range(40) - 20));
      3: return 16'($signed($urandom_range(2000) - 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  logic [15:0] edge_vals [7] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                 16'd1000, 16'hFC18};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_sample(0, 0, 0);
    send_sample(16'd500, 0, 0);
    send_sample(16'hFE0C, 0, 0);
    send_sample(0, 16'd700, 0);
    send_sample(0, 16'hFD44, 0);
    send_sample(0, 0, 16'd1000);
    send_sample(0, 0, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 0);
    send_sample(16'h7FFF, 16'h8000, 16'h0001);
    send_sample(16'h0001, 16'hFFFF, 16'h8000);
    send_sample(16'd1000, 16'd1000, 16'd0);
    for (int i = 0; i < 12; i++)
      send_sample(edge_vals[$urandom_range(6)], edge_vals[$urandom_range(6)],
                  edge_vals[$urandom_range(6)]);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 31 : 0;
      for (int i = 0; i < 317; i++) begin
        if ($urandom_range(9) == 0)
          send_sample(rand_axis(), rand_axis(), 0);
        else
          send_sample(rand_axis(), rand_axis(), rand_axis());
        if (phase == 2 && $urandom_range(19) == 0) begin
          recv_idle_pct = 0;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
